>>> rtl/core/swb_pkg.sv
package swb_pkg;

    // ring geometry
    localparam int CAPACITY = 16;
    localparam int MAX_RUN  = 16;
    localparam int RUN_MAX  = (MAX_RUN < CAPACITY) ? MAX_RUN : CAPACITY;
    localparam int POS_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // field widths
    localparam int SEQ_W  = 32;
    localparam int TIME_W = 64;
    localparam int LEN_W  = 32;
    localparam int REF_W  = 32;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLIDING_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EMIT_LIMIT   = 2'd2;

    // input commands
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // one stored entry
    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] time_ns;
        logic [LEN_W-1:0]  length;
        logic [REF_W-1:0]  handle;
    } t_swb_entry;

    localparam int ENTRY_W = $bits(t_swb_entry);

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd_issue;
    } t_swb_cmd;

    // datapath to controller
    typedef struct packed {
        logic run_pend;
        logic left_one;
        logic out_free;
    } t_swb_sts;

    // ring position plus offset, offset at most one full ring
    function automatic logic [POS_W-1:0] wrap_add(input logic [POS_W-1:0] pos,
                                                  input logic [CNT_W-1:0] add);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(pos) + (CNT_W+1)'(add);
        if (sum >= (CNT_W+1)'(CAPACITY)) begin
            sum = sum - (CNT_W+1)'(CAPACITY);
        end
        return POS_W'(sum);
    endfunction

    function automatic logic [CNT_W-1:0] cnt_min(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

>>> rtl/core/swb_in_if.sv
interface swb_in_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [swb_pkg::SEQ_W-1:0]   item_seq;
    logic [swb_pkg::TIME_W-1:0]  item_time_ns;
    logic [swb_pkg::LEN_W-1:0]   item_length;
    logic [swb_pkg::REF_W-1:0]   item_ref;

    modport source (output valid, command, item_seq, item_time_ns, item_length, item_ref,
                    input ready);
    modport sink (input valid, command, item_seq, item_time_ns, item_length, item_ref,
                  output ready);
endinterface

>>> rtl/core/swb_out_if.sv
interface swb_out_if;
    logic                        valid;
    logic                        ready;
    logic [swb_pkg::SEQ_W-1:0]   out_seq;
    logic [swb_pkg::TIME_W-1:0]  out_time_ns;
    logic [swb_pkg::LEN_W-1:0]   out_length;
    logic [swb_pkg::REF_W-1:0]   out_ref;
    logic                        last;

    modport source (output valid, out_seq, out_time_ns, out_length, out_ref, last,
                    input ready);
    modport sink (input valid, out_seq, out_time_ns, out_length, out_ref, last,
                  output ready);
endinterface

>>> rtl/core/swb_ram.sv
module swb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/swb_ctrl.sv
module swb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  swb_pkg::t_swb_sts i_sts,
    output swb_pkg::t_swb_cmd o_cmd
);
    import swb_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EMIT = 1'b1;

    logic r_state;
    logic n_state;
    logic accept;

    assign o_in_ready   = (r_state == S_IDLE);
    assign accept       = i_in_valid && o_in_ready;
    assign o_cmd.load   = accept;
    assign o_cmd.rd_issue = (r_state == S_EMIT) && i_sts.out_free;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_sts.run_pend) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (o_cmd.rd_issue && i_sts.left_one) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

>>> rtl/core/swb_datapath.sv
module swb_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [swb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [swb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_command,
    input  swb_pkg::t_swb_entry           i_entry,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output swb_pkg::t_swb_entry           o_entry,
    output logic                          o_last,
    input  swb_pkg::t_swb_cmd             i_cmd,
    output swb_pkg::t_swb_sts             o_sts
);
    import swb_pkg::*;

    // configuration
    logic [CFG_DATA_W-1:0] r_win;
    logic                  r_slide;
    logic [CFG_DATA_W-1:0] r_lim;

    // window and run state
    logic [CNT_W-1:0] r_fill;
    logic [POS_W-1:0] r_oldest;
    logic [POS_W-1:0] r_rd_pos;
    logic [CNT_W-1:0] r_left;
    logic             r_o_valid;
    logic             r_last;

    logic [CNT_W-1:0] eff_w;
    logic [CNT_W-1:0] eff_lim;
    logic [CNT_W-1:0] fill_a;
    logic [POS_W-1:0] old_a;
    logic [CNT_W-1:0] run_n;
    logic [POS_W-1:0] start;
    logic [CNT_W-1:0] n_fill;
    logic [POS_W-1:0] n_oldest;
    logic             st_we;
    logic [POS_W-1:0] waddr;
    logic [ENTRY_W-1:0] rdata;

    // saturated window size and run limit
    assign eff_w   = (32'(r_win) > 32'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(r_win);
    assign eff_lim = (32'(r_lim) > 32'(RUN_MAX))  ? CNT_W'(RUN_MAX)  : CNT_W'(r_lim);

    // window update and run setup for the item on the input
    always_comb begin
        fill_a   = r_fill;
        old_a    = r_oldest;
        run_n    = '0;
        start    = r_oldest;
        n_fill   = r_fill;
        n_oldest = r_oldest;
        st_we    = 1'b0;
        waddr    = wrap_add(r_oldest, r_fill);
        if (i_command == CMD_FLUSH) begin
            run_n    = cnt_min(r_fill, eff_lim);
            n_fill   = '0;
            n_oldest = '0;
        end else if (eff_w == '0) begin
            run_n = '0;
        end else if (r_slide) begin
            // drop the oldest down to one short of the window, then store
            if (r_fill >= eff_w) begin
                old_a  = wrap_add(r_oldest, r_fill - eff_w + CNT_W'(1));
                fill_a = eff_w - CNT_W'(1);
            end
            st_we    = 1'b1;
            waddr    = wrap_add(old_a, fill_a);
            n_fill   = fill_a + CNT_W'(1);
            n_oldest = old_a;
            run_n    = cnt_min(fill_a + CNT_W'(1), eff_lim);
            start    = old_a;
        end else begin
            // tumbling: gather, emit and empty once full
            if (r_fill < eff_w) begin
                st_we  = 1'b1;
                fill_a = r_fill + CNT_W'(1);
            end
            if (fill_a >= eff_w) begin
                run_n    = cnt_min(fill_a, eff_lim);
                n_fill   = '0;
                n_oldest = '0;
            end else begin
                n_fill = fill_a;
            end
        end
    end

    // item store
    swb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && st_we),
        .i_waddr (waddr),
        .i_wdata (i_entry),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_rd_pos),
        .o_rdata (rdata)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= CFG_DATA_W'(16);
            r_slide <= 1'b0;
            r_lim   <= CFG_DATA_W'(16);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WINDOW_SIZE:  r_win   <= i_cfg_data;
                CFG_SLIDING_MODE: r_slide <= i_cfg_data[0];
                CFG_EMIT_LIMIT:   r_lim   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // window state and run counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_oldest  <= '0;
            r_rd_pos  <= '0;
            r_left    <= '0;
            r_o_valid <= 1'b0;
            r_last    <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_fill   <= n_fill;
                r_oldest <= n_oldest;
                r_left   <= run_n;
                r_rd_pos <= start;
            end else if (i_cmd.rd_issue) begin
                r_left   <= r_left - CNT_W'(1);
                r_rd_pos <= wrap_add(r_rd_pos, CNT_W'(1));
            end
            if (i_cmd.rd_issue) begin
                r_o_valid <= 1'b1;
                r_last    <= (r_left == CNT_W'(1));
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_entry      = rdata;
    assign o_last       = r_last;
    assign o_sts.run_pend = (run_n != '0);
    assign o_sts.left_one = (r_left == CNT_W'(1));
    assign o_sts.out_free = !r_o_valid || i_out_ready;

    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= 32'(CAPACITY))
        else $error("fill count above capacity");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (r_left == '0))
        else $error("item taken while a run is still being read");

    a_last_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd_issue && r_left == CNT_W'(1)) |=> (r_o_valid && r_last && r_left == '0))
        else $error("final read of a run not marked last");
endmodule

>>> rtl/core/stream_window_buffer_unit.sv
// Sliding/tumbling window over a stream of items held in a 16-entry ring RAM.
// An input item is taken while no run is being read out; a push
// or flush that emits n items (n = min(held items, emit limit)) then reads
// the ring one entry per cycle, while the output is not stalled, through
// the single RAM read port, and the next input is taken only once the
// last of the n entries has been read. An item that emits nothing is taken
// every cycle. The last result may still be waiting on the output while
// the next input is accepted. There is no clearing pass.
module stream_window_buffer_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [swb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [swb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    swb_in_if.sink                         i_in,
    swb_out_if.source                      o_out
);
    import swb_pkg::*;

    t_swb_cmd   cmd;
    t_swb_sts   sts;
    t_swb_entry in_entry;
    t_swb_entry out_entry;

    assign in_entry.seq     = i_in.item_seq;
    assign in_entry.time_ns = i_in.item_time_ns;
    assign in_entry.length  = i_in.item_length;
    assign in_entry.handle  = i_in.item_ref;

    // sequencing
    swb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // window state, ring store and output register
    swb_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_command   (i_in.command),
        .i_entry     (in_entry),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_entry     (out_entry),
        .o_last      (o_out.last),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    assign o_out.out_seq     = out_entry.seq;
    assign o_out.out_time_ns = out_entry.time_ns;
    assign o_out.out_length  = out_entry.length;
    assign o_out.out_ref     = out_entry.handle;
endmodule

>>> tb/stream_window_buffer_unit_tb.sv
module stream_window_buffer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swb_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    // a full window read out plus margin, before any register write
    localparam int SETTLE_CYCLES = 24;

    // one emitted item as the window copy predicts it
    typedef struct packed {
        t_swb_entry item;
        logic       last;
    } t_emit;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    swb_in_if  in_ch ();
    swb_out_if out_ch ();

    stream_window_buffer_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // shadow copy of the window and its registers
    logic [CFG_DATA_W-1:0] win_size_reg = 5'd16;
    logic                  sliding_reg  = 1'b0;
    logic [CFG_DATA_W-1:0] limit_reg    = 5'd16;
    t_swb_entry            win_ring [CAPACITY];
    logic [CNT_W-1:0]      win_fill     = '0;
    logic [POS_W-1:0]      win_oldest   = '0;
    t_emit                 pending_emits [$];

    int fail_count      = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int hold_off_cycles = 0;
    int cycle_count     = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run guard
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // queue the oldest held items, cut at the emit limit
    function automatic void queue_window_run();
        int    n;
        int    slot;
        t_emit nxt;
        n = (int'(limit_reg) > RUN_MAX) ? RUN_MAX : int'(limit_reg);
        if (int'(win_fill) < n) begin
            n = int'(win_fill);
        end
        for (int i = 0; i < n; i++) begin
            slot     = (int'(win_oldest) + i) % CAPACITY;
            nxt.item = win_ring[slot];
            nxt.last = (i == n - 1);
            pending_emits.push_back(nxt);
        end
    endfunction

    // apply one accepted item to the window copy
    function automatic void advance_window(input logic cmd, input t_swb_entry e);
        int win;
        int drop;
        win = (int'(win_size_reg) > CAPACITY) ? CAPACITY : int'(win_size_reg);
        if (cmd == CMD_FLUSH) begin
            queue_window_run();
            win_fill   = '0;
            win_oldest = '0;
            return;
        end
        if (win == 0) begin
            return;
        end
        if (sliding_reg) begin
            // drop the oldest down to one below the window, then store
            if (int'(win_fill) >= win) begin
                drop       = int'(win_fill) - win + 1;
                win_oldest = POS_W'((int'(win_oldest) + drop) % CAPACITY);
                win_fill   = CNT_W'(win - 1);
            end
            win_ring[(int'(win_oldest) + int'(win_fill)) % CAPACITY] = e;
            win_fill++;
            queue_window_run();
        end else begin
            // tumbling: a shrunk window drops the new item
            if (int'(win_fill) < win) begin
                win_ring[(int'(win_oldest) + int'(win_fill)) % CAPACITY] = e;
                win_fill++;
            end
            if (int'(win_fill) >= win) begin
                queue_window_run();
                win_fill   = '0;
                win_oldest = '0;
            end
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] expected,
                                        input logic [63:0] actual);
        if (actual !== expected) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, expected, actual);
            fail_count++;
        end
    endfunction

    // sample both channels at each edge: predict first, then check
    initial begin
        t_swb_entry seen;
        t_emit      want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && in_ch.valid && in_ch.ready) begin
                seen.seq     = in_ch.item_seq;
                seen.time_ns = in_ch.item_time_ns;
                seen.length  = in_ch.item_length;
                seen.handle  = in_ch.item_ref;
                advance_window(in_ch.command, seen);
            end
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (pending_emits.size() == 0) begin
                    $error("item emitted with nothing expected: out_seq 0x%0h", out_ch.out_seq);
                    fail_count++;
                end else begin
                    want = pending_emits.pop_front();
                    check_field("out_seq", want.item.seq, out_ch.out_seq);
                    check_field("out_time_ns", want.item.time_ns, out_ch.out_time_ns);
                    check_field("out_length", want.item.length, out_ch.out_length);
                    check_field("out_ref", want.item.handle, out_ch.out_ref);
                    check_field("last", want.last, out_ch.last);
                end
            end
        end
    end

    // receiver: random stalls, or a long hold-off when asked
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles > 0) begin
                out_ch.ready <= 1'b0;
                hold_off_cycles--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic t_swb_entry random_entry();
        t_swb_entry e;
        int         pick;
        pick      = $urandom_range(19);
        e.seq     = $urandom;
        e.time_ns = {$urandom, $urandom};
        e.length  = $urandom;
        e.handle  = $urandom;
        if (pick == 0) begin
            e = '0;
        end else if (pick == 1) begin
            e = '1;
        end
        return e;
    endfunction

    // offer one item after a random gap, return once it is taken
    task automatic send_item(input logic cmd, input t_swb_entry e);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.command      <= cmd;
        in_ch.item_seq     <= e.seq;
        in_ch.item_time_ns <= e.time_ns;
        in_ch.item_length  <= e.length;
        in_ch.item_ref     <= e.handle;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // stop offering and wait until the block has gone quiet
    task automatic settle_window();
        in_ch.valid <= 1'b0;
        // let the monitor record the last accepted item first
        @(posedge i_clk);
        while (pending_emits.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write all three registers while the block is idle
    task automatic configure(input logic [CFG_DATA_W-1:0] ws, input logic mode,
                             input logic [CFG_DATA_W-1:0] lim);
        settle_window();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_WINDOW_SIZE;
        cfg_data <= ws;
        @(posedge i_clk);
        win_size_reg = ws;
        cfg_idx  <= CFG_SLIDING_MODE;
        cfg_data <= CFG_DATA_W'(mode);
        @(posedge i_clk);
        sliding_reg = mode;
        cfg_idx  <= CFG_EMIT_LIMIT;
        cfg_data <= lim;
        @(posedge i_clk);
        limit_reg = lim;
        cfg_we <= 1'b0;
    endtask

    task automatic test_tumbling_runs();
        configure(5'd3, 1'b0, 5'd16);
        send_item(CMD_PUSH, '1);
        send_item(CMD_PUSH, '0);
        send_item(CMD_PUSH, random_entry());
        // flush with nothing held
        send_item(CMD_FLUSH, random_entry());
        // run cut at two, the rest of the window discarded
        configure(5'd4, 1'b0, 5'd2);
        repeat (4) send_item(CMD_PUSH, random_entry());
    endtask

    task automatic test_sliding_runs();
        // limit above the run size saturates
        configure(5'd3, 1'b1, 5'd31);
        repeat (3) send_item(CMD_PUSH, random_entry());
        // window shrunk below fill: oldest dropped before the store
        configure(5'd1, 1'b1, 5'd31);
        send_item(CMD_PUSH, random_entry());
        // window above capacity saturates, runs cut at two
        configure(5'd20, 1'b1, 5'd2);
        repeat (2) send_item(CMD_PUSH, random_entry());
        send_item(CMD_FLUSH, random_entry());
    endtask

    task automatic test_window_corners();
        // tumbling window shrunk below fill: new item dropped, held ones emitted
        configure(5'd4, 1'b0, 5'd16);
        repeat (2) send_item(CMD_PUSH, random_entry());
        configure(5'd1, 1'b0, 5'd16);
        send_item(CMD_PUSH, random_entry());
        // zero limit: empty run, window still emptied
        configure(5'd1, 1'b0, 5'd0);
        send_item(CMD_PUSH, random_entry());
        send_item(CMD_FLUSH, random_entry());
        // zero window: push ignored, flush still emits what is held
        configure(5'd3, 1'b0, 5'd16);
        send_item(CMD_PUSH, random_entry());
        configure(5'd0, 1'b0, 5'd16);
        send_item(CMD_PUSH, random_entry());
        send_item(CMD_FLUSH, random_entry());
    endtask

    task automatic test_backpressure();
        configure(5'd16, 1'b1, 5'd16);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // receiver holds off while growing sliding-window runs keep coming
        hold_off_cycles = 300;
        repeat (12) send_item(CMD_PUSH, random_entry());
        send_item(CMD_FLUSH, random_entry());
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        logic [CFG_DATA_W-1:0] ws;
        logic [CFG_DATA_W-1:0] lim;
        int                    pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (2) begin
            pick = $urandom_range(99);
            if (pick < 3) begin
                ws = 5'd0;
            end else if (pick < 12) begin
                ws = CFG_DATA_W'($urandom_range(17, 31));
            end else if (pick < 30) begin
                ws = 5'd16;
            end else begin
                ws = CFG_DATA_W'($urandom_range(1, 15));
            end
            pick = $urandom_range(99);
            if (pick < 6) begin
                lim = 5'd0;
            end else if (pick < 18) begin
                lim = CFG_DATA_W'($urandom_range(17, 31));
            end else if (pick < 35) begin
                lim = 5'd16;
            end else begin
                lim = CFG_DATA_W'($urandom_range(1, 15));
            end
            configure(ws, 1'($urandom_range(1)), lim);
            repeat (24) begin
                send_item(($urandom_range(99) < 8) ? CMD_FLUSH : CMD_PUSH, random_entry());
            end
        end
    endtask

    // stimulus
    initial begin
        in_ch.valid        <= 1'b0;
        in_ch.command      <= CMD_PUSH;
        in_ch.item_seq     <= '0;
        in_ch.item_time_ns <= '0;
        in_ch.item_length  <= '0;
        in_ch.item_ref     <= '0;
        cfg_we             <= 1'b0;
        cfg_idx            <= CFG_WINDOW_SIZE;
        cfg_data           <= '0;
        i_rst_n            <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_tumbling_runs();
        test_sliding_runs();
        test_window_corners();
        test_backpressure();
        test_random_traffic(0, 0);
        test_random_traffic(53, 0);
        test_random_traffic(0, 53);
        test_random_traffic(10, 10);

        settle_window();
        if (fail_count == 0 && pending_emits.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> stream_window_buffer_unit.f
rtl/core/swb_pkg.sv
rtl/core/swb_in_if.sv
rtl/core/swb_out_if.sv
rtl/core/swb_ram.sv
rtl/core/swb_ctrl.sv
rtl/core/swb_datapath.sv
rtl/core/stream_window_buffer_unit.sv
tb/stream_window_buffer_unit_tb.sv
